// File: rtl/i2cm_pkg.sv
// Package for the I2C master register access block.
// Holds phase codes, stage codes, status codes and sizing constants; no dependencies.
`default_nettype none
package i2cm_pkg;
  localparam int MaxBytes = 16;
  localparam logic [7:0] AckTimeoutReset = 8'd200;

  localparam logic [3:0] PH_IDLE = 4'd0;
  localparam logic [3:0] PH_S_HIGH = 4'd1;
  localparam logic [3:0] PH_S_FALL = 4'd2;
  localparam logic [3:0] PH_S_LOW = 4'd3;
  localparam logic [3:0] PH_RS_PREP = 4'd4;
  localparam logic [3:0] PH_TX_LOW = 4'd5;
  localparam logic [3:0] PH_TX_HIGH = 4'd6;
  localparam logic [3:0] PH_ACK_REL = 4'd7;
  localparam logic [3:0] PH_ACK_WAIT = 4'd8;
  localparam logic [3:0] PH_RX_LOW = 4'd9;
  localparam logic [3:0] PH_RX_HIGH = 4'd10;
  localparam logic [3:0] PH_MA_LOW = 4'd11;
  localparam logic [3:0] PH_MA_HIGH = 4'd12;
  localparam logic [3:0] PH_P_LOW = 4'd13;
  localparam logic [3:0] PH_P_HIGH = 4'd14;
  localparam logic [3:0] PH_P_END = 4'd15;

  localparam logic [1:0] STG_ADDR = 2'd0;
  localparam logic [1:0] STG_REG = 2'd1;
  localparam logic [1:0] STG_DATA = 2'd2;
  localparam logic [1:0] STG_RADDR = 2'd3;

  localparam logic [1:0] ST_OK = 2'd0;
  localparam logic [1:0] ST_ADDR_NACK = 2'd1;
  localparam logic [1:0] ST_REG_NACK = 2'd2;
  localparam logic [1:0] ST_DATA_NACK = 2'd3;

  typedef struct packed {
    logic [7:0] dev;
    logic [7:0] regi;
    logic [4:0] count;
    logic       mode;
    logic       cmd;
    logic       load;
    logic [7:0] load_data;
    logic       sda_in;
  } tick_t;

  typedef struct packed {
    logic       scl;
    logic       sda;
    logic       busy;
    logic       rvalid;
    logic [7:0] rdata;
    logic       done;
    logic [1:0] status;
  } res_t;
endpackage
`default_nettype wire

// File: rtl/i2cm_ram.sv
// Generic single-port-write RAM with registered read.
// No dependencies.
`default_nettype none
module i2cm_ram #(
  parameter int Width = 8,
  parameter int Depth = 16
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(Depth)-1:0] waddr,
  input  wire logic [Width-1:0]         wdata,
  input  wire logic [$clog2(Depth)-1:0] raddr,
  output logic      [Width-1:0]         rdata
);
  logic [Width-1:0] mem [Depth];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end
endmodule
`default_nettype wire

// File: rtl/i2cm_front.sv
// Front part: accepts requests into a two-entry queue.
// Depends on i2cm_pkg.
`default_nettype none
module i2cm_front (
  input  wire logic           clk,
  input  wire logic           rst,
  input  wire logic           in_valid,
  output logic                in_stall,
  input  wire i2cm_pkg::tick_t in_data,
  output logic                q_valid,
  input  wire logic           q_take,
  output i2cm_pkg::tick_t     q_data
);
  import i2cm_pkg::*;

  tick_t entry [2];
  logic [1:0] count;
  logic rd, wr;
  logic push, pop;

  assign in_stall = (count == 2'd2);
  assign push = in_valid && !in_stall;
  assign q_valid = (count != 2'd0);
  assign pop = q_valid && q_take;
  assign q_data = entry[rd];

  always_ff @(posedge clk) begin
    if (rst) begin
      count <= 2'd0;
      rd <= 1'b0;
      wr <= 1'b0;
    end else begin
      if (push) begin
        wr <= !wr;
      end
      if (pop) begin
        rd <= !rd;
      end
      count <= count + {1'b0, push} - {1'b0, pop};
    end
    if (push) begin
      entry[wr] <= in_data;
    end
  end
endmodule
`default_nettype wire

// File: rtl/i2cm_back.sv
// Back part: the I2C bit sequencer and its output register.
// Depends on i2cm_pkg and i2cm_ram.
`default_nettype none
module i2cm_back #(
  parameter int MaxBytes = i2cm_pkg::MaxBytes
) (
  input  wire logic            clk,
  input  wire logic            rst,
  input  wire logic            cfg_we,
  input  wire logic [7:0]      cfg_data,
  input  wire logic            q_valid,
  output logic                 q_take,
  input  wire i2cm_pkg::tick_t q_data,
  output logic                 out_valid,
  input  wire logic            out_stall,
  output i2cm_pkg::res_t       out_data
);
  import i2cm_pkg::*;

  localparam int AW = (MaxBytes > 1) ? $clog2(MaxBytes) : 1;
  localparam logic [4:0] MaxB = 5'(MaxBytes);

  logic [7:0] ack_timeout;
  logic [3:0] phase, phase_next;
  logic [2:0] bit_index, bit_index_next;
  logic [4:0] byte_index, byte_index_next;
  logic [7:0] shift_reg, shift_reg_next;
  logic [7:0] wait_count, wait_count_next;
  logic [4:0] buffer_fill, buffer_fill_next;
  logic [7:0] dev, dev_next, regi, regi_next;
  logic [4:0] count, count_next;
  logic mode, mode_next;
  logic [1:0] stage, stage_next, end_status, end_status_next;
  logic [4:0] pf_idx, pf_idx_next;
  logic [7:0] buf_rdata;
  logic buf_we;
  logic [AW-1:0] buf_raddr;
  res_t r;
  logic go;
  logic [4:0] inc_idx, cnt_sat;
  logic [7:0] rx_byte;
  logic ma_bit;

  // The next write byte is prefetched: its index is known one tick ahead.
  assign buf_raddr = go ? pf_idx_next[AW-1:0] : pf_idx[AW-1:0];
  i2cm_ram #(.Width(8), .Depth(MaxBytes)) u_buf (
    .clk(clk), .we(buf_we), .waddr(buffer_fill[AW-1:0]), .wdata(q_data.load_data),
    .raddr(buf_raddr), .rdata(buf_rdata)
  );

  assign q_take = !out_valid || !out_stall;
  assign go = q_valid && q_take;
  assign buf_we = go && (phase == PH_IDLE) && q_data.load && (buffer_fill < MaxB);
  assign inc_idx = byte_index + 5'd1;
  assign cnt_sat = (q_data.count > MaxB) ? MaxB : q_data.count;
  assign rx_byte = shift_reg | (8'(q_data.sda_in) << bit_index);
  assign ma_bit = (inc_idx >= count);

  always_comb begin
    phase_next = phase;
    bit_index_next = bit_index;
    byte_index_next = byte_index;
    shift_reg_next = shift_reg;
    wait_count_next = wait_count;
    buffer_fill_next = buffer_fill;
    dev_next = dev;
    regi_next = regi;
    count_next = count;
    mode_next = mode;
    stage_next = stage;
    end_status_next = end_status;
    pf_idx_next = pf_idx;
    r = '0;
    r.scl = 1'b1;
    r.sda = 1'b1;
    r.busy = 1'b1;
    case (phase)
      PH_IDLE: begin
        r.busy = 1'b0;
        if (buf_we) begin
          buffer_fill_next = buffer_fill + 5'd1;
        end
        if (q_data.cmd) begin
          count_next = cnt_sat;
          regi_next = q_data.regi;
          dev_next = q_data.dev;
          mode_next = q_data.mode;
          stage_next = STG_ADDR;
          byte_index_next = 5'd0;
          end_status_next = ST_OK;
          pf_idx_next = 5'd0;
          phase_next = PH_S_FALL;
        end
      end
      PH_RS_PREP: begin
        r.scl = 1'b0;
        phase_next = PH_S_HIGH;
      end
      PH_S_HIGH: phase_next = PH_S_FALL;
      PH_S_FALL: begin
        r.sda = 1'b0;
        phase_next = PH_S_LOW;
      end
      PH_S_LOW: begin
        r.scl = 1'b0;
        r.sda = 1'b0;
        shift_reg_next = (stage == STG_RADDR) ? (dev | 8'h01) : (dev & 8'hFE);
        bit_index_next = 3'd7;
        phase_next = PH_TX_LOW;
      end
      PH_TX_LOW: begin
        r.scl = 1'b0;
        r.sda = shift_reg[bit_index];
        phase_next = PH_TX_HIGH;
      end
      PH_TX_HIGH: begin
        r.sda = shift_reg[bit_index];
        if (bit_index == 3'd0) begin
          phase_next = PH_ACK_REL;
        end else begin
          bit_index_next = bit_index - 3'd1;
          phase_next = PH_TX_LOW;
        end
      end
      PH_ACK_REL: begin
        r.scl = 1'b0;
        wait_count_next = 8'd0;
        phase_next = PH_ACK_WAIT;
      end
      PH_ACK_WAIT: begin
        if (!q_data.sda_in) begin
          bit_index_next = 3'd7;
          case (stage)
            STG_ADDR: begin
              stage_next = STG_REG;
              shift_reg_next = regi;
              phase_next = PH_TX_LOW;
            end
            STG_REG: begin
              byte_index_next = 5'd0;
              if (mode) begin
                stage_next = STG_RADDR;
                phase_next = PH_RS_PREP;
              end else if (count == 5'd0) begin
                end_status_next = ST_OK;
                phase_next = PH_P_LOW;
              end else begin
                stage_next = STG_DATA;
                shift_reg_next = buf_rdata;
                pf_idx_next = 5'd1;
                phase_next = PH_TX_LOW;
              end
            end
            STG_DATA: begin
              byte_index_next = inc_idx;
              if (inc_idx >= count) begin
                end_status_next = ST_OK;
                phase_next = PH_P_LOW;
              end else begin
                shift_reg_next = (inc_idx < MaxB) ? buf_rdata : 8'd0;
                pf_idx_next = inc_idx + 5'd1;
                phase_next = PH_TX_LOW;
              end
            end
            default: begin
              byte_index_next = 5'd0;
              if (count == 5'd0) begin
                end_status_next = ST_OK;
                phase_next = PH_P_LOW;
              end else begin
                shift_reg_next = 8'd0;
                phase_next = PH_RX_LOW;
              end
            end
          endcase
        end else if (wait_count >= ack_timeout) begin
          end_status_next = (stage == STG_ADDR) ? ST_ADDR_NACK :
                            ((stage == STG_REG) ? ST_REG_NACK : ST_DATA_NACK);
          phase_next = PH_P_LOW;
        end else begin
          wait_count_next = wait_count + 8'd1;
        end
      end
      PH_RX_LOW: begin
        r.scl = 1'b0;
        phase_next = PH_RX_HIGH;
      end
      PH_RX_HIGH: begin
        shift_reg_next = rx_byte;
        if (bit_index == 3'd0) begin
          r.rvalid = 1'b1;
          r.rdata = rx_byte;
          phase_next = PH_MA_LOW;
        end else begin
          bit_index_next = bit_index - 3'd1;
          phase_next = PH_RX_LOW;
        end
      end
      PH_MA_LOW: begin
        r.scl = 1'b0;
        r.sda = ma_bit;
        phase_next = PH_MA_HIGH;
      end
      PH_MA_HIGH: begin
        r.sda = ma_bit;
        byte_index_next = inc_idx;
        if (ma_bit) begin
          end_status_next = ST_OK;
          phase_next = PH_P_LOW;
        end else begin
          shift_reg_next = 8'd0;
          bit_index_next = 3'd7;
          phase_next = PH_RX_LOW;
        end
      end
      PH_P_LOW: begin
        r.scl = 1'b0;
        r.sda = 1'b0;
        phase_next = PH_P_HIGH;
      end
      PH_P_HIGH: begin
        r.sda = 1'b0;
        phase_next = PH_P_END;
      end
      default: begin
        r.busy = 1'b0;
        r.done = 1'b1;
        r.status = end_status;
        buffer_fill_next = 5'd0;
        phase_next = PH_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      ack_timeout <= AckTimeoutReset;
      phase <= PH_IDLE;
      bit_index <= 3'd7;
      byte_index <= 5'd0;
      shift_reg <= 8'd0;
      wait_count <= 8'd0;
      buffer_fill <= 5'd0;
      dev <= 8'd0;
      regi <= 8'd0;
      count <= 5'd0;
      mode <= 1'b0;
      stage <= STG_ADDR;
      end_status <= ST_OK;
      pf_idx <= 5'd0;
      out_valid <= 1'b0;
    end else begin
      if (cfg_we) begin
        ack_timeout <= cfg_data;
      end
      if (go) begin
        phase <= phase_next;
        bit_index <= bit_index_next;
        byte_index <= byte_index_next;
        shift_reg <= shift_reg_next;
        wait_count <= wait_count_next;
        buffer_fill <= buffer_fill_next;
        dev <= dev_next;
        regi <= regi_next;
        count <= count_next;
        mode <= mode_next;
        stage <= stage_next;
        end_status <= end_status_next;
        pf_idx <= pf_idx_next;
        out_valid <= 1'b1;
        out_data <= r;
      end else if (!out_stall) begin
        out_valid <= 1'b0;
      end
    end
  end
endmodule
`default_nettype wire

// File: rtl/i2c_master_register_access.sv
// I2C master register access: one request is one bus tick, one result per request.
// A request passes through the queue and then the output register before its result appears.
// Throughput: one request per cycle while out_stall is low, set by the single-tick bit sequencer.
// Reset (rst, synchronous): idle, empty queue and buffer, ack_timeout 200.
// Depends on i2cm_pkg, i2cm_front, i2cm_back and i2cm_ram.
`default_nettype none
module i2c_master_register_access #(
  parameter int MaxBytes = i2cm_pkg::MaxBytes
) (
  input  wire logic       clk,
  input  wire logic       rst,
  input  wire logic       cfg_we,
  input  wire logic [7:0] cfg_data,
  input  wire logic       in_valid,
  output logic            in_stall,
  input  wire logic       mode,
  input  wire logic       cmd_valid,
  input  wire logic [7:0] device_address,
  input  wire logic [7:0] register_address,
  input  wire logic [4:0] byte_count,
  input  wire logic       load_valid,
  input  wire logic [7:0] load_data,
  input  wire logic       sda_in,
  output logic            out_valid,
  input  wire logic       out_stall,
  output logic            scl_out,
  output logic            sda_out,
  output logic            busy_res,
  output logic            read_valid,
  output logic [7:0]      read_data,
  output logic            done_res,
  output logic [1:0]      status
);
  import i2cm_pkg::*;

  tick_t in_data, q_data;
  res_t res;
  logic q_valid, q_take;

  assign in_data = '{dev: device_address, regi: register_address, count: byte_count,
                     mode: mode, cmd: cmd_valid, load: load_valid,
                     load_data: load_data, sda_in: sda_in};

  i2cm_front u_front (
    .clk(clk), .rst(rst), .in_valid(in_valid), .in_stall(in_stall), .in_data(in_data),
    .q_valid(q_valid), .q_take(q_take), .q_data(q_data)
  );

  i2cm_back #(.MaxBytes(MaxBytes)) u_back (
    .clk(clk), .rst(rst), .cfg_we(cfg_we), .cfg_data(cfg_data),
    .q_valid(q_valid), .q_take(q_take), .q_data(q_data),
    .out_valid(out_valid), .out_stall(out_stall), .out_data(res)
  );

  assign scl_out = res.scl;
  assign sda_out = res.sda;
  assign busy_res = res.busy;
  assign read_valid = res.rvalid;
  assign read_data = res.rdata;
  assign done_res = res.done;
  assign status = res.status;
endmodule
`default_nettype wire
